@@ src/ohp_pkg.sv @@
// Shared types, constants and the magic table for the Opus ID header parser.
package ohp_pkg;

  // Byte positions within the identification header
  localparam logic [8:0] POS_VERSION  = 9'd8;
  localparam logic [8:0] POS_CHANNELS = 9'd9;
  localparam logic [8:0] POS_PRESKIP  = 9'd10;
  localparam logic [8:0] POS_RATE     = 9'd12;
  localparam logic [8:0] POS_GAIN     = 9'd16;
  localparam logic [8:0] POS_FAMILY   = 9'd18;
  localparam logic [8:0] POS_STREAMS  = 9'd19;
  localparam logic [8:0] POS_COUPLED  = 9'd20;
  localparam logic [8:0] POS_MAP      = 9'd21;
  localparam logic [8:0] COUNT_MAX    = 9'd511;

  localparam logic [7:0] VERSION_MASK = 8'hF0;
  localparam logic [7:0] SILENT       = 8'hFF;
  localparam logic [9:0] MIN_LEN      = 10'd19;
  localparam logic [9:0] MAP_BASE     = 10'd21;

  localparam int QDEPTH = 2;

  // Position class assigned by the front end
  typedef enum logic [3:0] {
    CLS_MAGIC,
    CLS_VERSION,
    CLS_CHANNELS,
    CLS_PRESKIP,
    CLS_RATE,
    CLS_GAIN,
    CLS_FAMILY,
    CLS_STREAMS,
    CLS_COUPLED,
    CLS_MAP
  } cls_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic              result_kind;
    logic              header_ok;
    logic [7:0]        version;
    logic [7:0]        channel_count;
    logic [15:0]       preskip;
    logic [31:0]       sample_rate;
    logic signed [15:0] output_gain;
    logic [7:0]        mapping_family;
    logic [7:0]        stream_count;
    logic [7:0]        coupled_count;
    logic [7:0]        map_index;
    logic [7:0]        map_value;
  } out_t;

  // Classified transaction passed from front to back
  typedef struct packed {
    cls_t       cls;
    logic [8:0] pos;
    logic [7:0] data_byte;
    logic       last_byte;
  } cmd_t;

  // "OpusHead"
  function automatic logic [7:0] magic_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0:    val = 8'h4F;
      3'd1:    val = 8'h70;
      3'd2:    val = 8'h75;
      3'd3:    val = 8'h73;
      3'd4:    val = 8'h48;
      3'd5:    val = 8'h65;
      3'd6:    val = 8'h61;
      default: val = 8'h64;
    endcase
    return val;
  endfunction

endpackage

@@ src/ohp_front.sv @@
// Front end: tracks byte position within the packet and classifies each byte.
module ohp_front import ohp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic push_ok,
  input  in_t  in_data,
  output logic push,
  output cmd_t cmd
);

  logic [8:0] pos;
  logic [8:0] pos_next;

  assign push = in_valid && push_ok;

  // Advance position, saturate on long packets, restart after the last byte
  always_comb begin
    pos_next = pos;
    if (push) begin
      if (in_data.last_byte) begin
        pos_next = '0;
      end else if (pos != COUNT_MAX) begin
        pos_next = pos + 9'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else begin
      pos <= pos_next;
    end
  end

  // Classify by position
  always_comb begin
    cmd.pos       = pos;
    cmd.data_byte = in_data.data_byte;
    cmd.last_byte = in_data.last_byte;
    if (pos < POS_VERSION)       cmd.cls = CLS_MAGIC;
    else if (pos == POS_VERSION)  cmd.cls = CLS_VERSION;
    else if (pos == POS_CHANNELS) cmd.cls = CLS_CHANNELS;
    else if (pos < POS_RATE)      cmd.cls = CLS_PRESKIP;
    else if (pos < POS_GAIN)      cmd.cls = CLS_RATE;
    else if (pos < POS_FAMILY)    cmd.cls = CLS_GAIN;
    else if (pos == POS_FAMILY)   cmd.cls = CLS_FAMILY;
    else if (pos == POS_STREAMS)  cmd.cls = CLS_STREAMS;
    else if (pos == POS_COUPLED)  cmd.cls = CLS_COUPLED;
    else                          cmd.cls = CLS_MAP;
  end

endmodule

@@ src/ohp_queue.sv @@
// Short FIFO of classified transactions between front and back.
module ohp_queue import ohp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(QDEPTH - 1);

  cmd_t          slots [QDEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  // Store pushed transactions
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ src/ohp_back.sv @@
// Back end: runs header checks, holds parsed fields, registers results.
module ohp_back import ohp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic pop,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic        failed, failed_next;
  logic [7:0]  version_reg, version_next;
  logic [7:0]  channels_reg, channels_next;
  logic [15:0] preskip_reg, preskip_next;
  logic [31:0] rate_reg, rate_next;
  logic [15:0] gain_reg, gain_next;
  logic [7:0]  family_reg, family_next;
  logic [7:0]  streams_reg, streams_next;
  logic [7:0]  coupled_reg, coupled_next;

  logic        ready;
  logic        has_result;
  out_t        result;
  logic        is_map;
  logic [8:0]  map_off;
  logic [8:0]  stream_sum;
  logic [8:0]  coupled_sum;
  logic [9:0]  len;
  logic [9:0]  need;
  logic        ok;
  logic [7:0]  b;

  assign ready = !out_valid || !out_stall;
  assign pop   = cmd_valid && ready;

  assign b           = cmd.data_byte;
  assign map_off     = cmd.pos - POS_MAP;
  assign stream_sum  = {1'b0, streams_reg} + {1'b0, coupled_reg};
  assign coupled_sum = {1'b0, b} + {1'b0, streams_reg};
  assign len         = {1'b0, cmd.pos} + 10'd1;

  // Check the byte and update parsed fields
  always_comb begin
    failed_next   = failed;
    version_next  = version_reg;
    channels_next = channels_reg;
    preskip_next  = preskip_reg;
    rate_next     = rate_reg;
    gain_next     = gain_reg;
    family_next   = family_reg;
    streams_next  = streams_reg;
    coupled_next  = coupled_reg;
    is_map        = 1'b0;
    if (!failed) begin
      case (cmd.cls)
        CLS_MAGIC: begin
          if (b != magic_byte(cmd.pos[2:0])) failed_next = 1'b1;
        end
        CLS_VERSION: begin
          version_next = b;
          if ((b & VERSION_MASK) != '0) failed_next = 1'b1;
        end
        CLS_CHANNELS: begin
          channels_next = b;
          if (b == '0) failed_next = 1'b1;
        end
        CLS_PRESKIP: begin
          if (cmd.pos[0]) preskip_next[15:8] = preskip_reg[15:8] | b;
          else            preskip_next[7:0]  = preskip_reg[7:0] | b;
        end
        CLS_RATE: begin
          case (cmd.pos[1:0])
            2'd0:    rate_next[7:0]   = rate_reg[7:0] | b;
            2'd1:    rate_next[15:8]  = rate_reg[15:8] | b;
            2'd2:    rate_next[23:16] = rate_reg[23:16] | b;
            default: rate_next[31:24] = rate_reg[31:24] | b;
          endcase
        end
        CLS_GAIN: begin
          if (cmd.pos[0]) gain_next[15:8] = gain_reg[15:8] | b;
          else            gain_next[7:0]  = gain_reg[7:0] | b;
        end
        CLS_FAMILY: begin
          family_next = b;
          if (b == '0) begin
            if (channels_reg > 8'd2) failed_next = 1'b1;
            streams_next = 8'd1;
            coupled_next = (channels_reg > 8'd1) ? 8'd1 : 8'd0;
          end
        end
        CLS_STREAMS: begin
          if (family_reg != '0) begin
            streams_next = b;
            if (b == '0) failed_next = 1'b1;
          end
        end
        CLS_COUPLED: begin
          if (family_reg != '0) begin
            coupled_next = b;
            if (b > streams_reg || coupled_sum > 9'd255) failed_next = 1'b1;
          end
        end
        CLS_MAP: begin
          if (family_reg != '0 && map_off < {1'b0, channels_reg}) begin
            if ({1'b0, b} >= stream_sum && b != SILENT) failed_next = 1'b1;
            else is_map = 1'b1;
          end
        end
        default: begin
          failed_next = failed;
        end
      endcase
    end
  end

  // Build the result: map entry or end-of-packet verdict
  always_comb begin
    need = (family_next == '0) ? MIN_LEN : MAP_BASE + {2'b00, channels_next};
    ok   = !failed_next && len >= MIN_LEN && len >= need;
    if (ok && version_next <= 8'd1 && len != need) ok = 1'b0;
    result     = '0;
    has_result = 1'b0;
    if (!cmd.last_byte) begin
      if (is_map && !failed_next) begin
        has_result       = 1'b1;
        result.map_index = map_off[7:0];
        result.map_value = b;
      end
    end else begin
      has_result         = 1'b1;
      result.result_kind = 1'b1;
      if (ok) begin
        result.header_ok      = 1'b1;
        result.version        = version_next;
        result.channel_count  = channels_next;
        result.preskip        = preskip_next;
        result.sample_rate    = rate_next;
        result.output_gain    = gain_next;
        result.mapping_family = family_next;
        result.stream_count   = streams_next;
        result.coupled_count  = coupled_next;
        if (is_map) begin
          result.map_index = map_off[7:0];
          result.map_value = b;
        end
      end
    end
  end

  // Update parse state; clear after every verdict
  always_ff @(posedge clk) begin
    if (rst || (pop && cmd.last_byte)) begin
      failed       <= 1'b0;
      version_reg  <= '0;
      channels_reg <= '0;
      preskip_reg  <= '0;
      rate_reg     <= '0;
      gain_reg     <= '0;
      family_reg   <= '0;
      streams_reg  <= '0;
      coupled_reg  <= '0;
    end else if (pop) begin
      failed       <= failed_next;
      version_reg  <= version_next;
      channels_reg <= channels_next;
      preskip_reg  <= preskip_next;
      rate_reg     <= rate_next;
      gain_reg     <= gain_next;
      family_reg   <= family_next;
      streams_reg  <= streams_next;
      coupled_reg  <= coupled_next;
    end
  end

  // Output register: load a new result or drop the one taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= pop && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && has_result) begin
      out_data <= result;
    end
  end

endmodule

@@ src/opus_id_header_parser.sv @@
// Opus identification header parser: top level joining front, queue and back.
// A result passes through a queue slot and the output register.
// Throughput: one byte per cycle when not stalled; the two-entry queue
// absorbs output stalls. Input stall rises only when the queue is full.
// Reset (synchronous, active high) clears byte position, queue, parse state
// and output valid; no clearing pass is needed.
module opus_id_header_parser import ohp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic pop;
  logic head_valid;
  cmd_t head;

  assign in_stall = q_full;

  ohp_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .push_ok (!q_full),
    .in_data (in_data),
    .push    (push),
    .cmd     (push_cmd)
  );

  ohp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head      (head)
  );

  ohp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(head_valid),
    .cmd      (head),
    .pop      (pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the Opus identification header parser.
module testbench;
  import ohp_pkg::*;

  localparam logic KIND_MAP     = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;
  localparam int RANDOM_BYTES = 1150;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int LONG_PACKET  = 5;

  typedef enum {PKT_FAMILY_ZERO, PKT_MAPPED, PKT_NOISE} pkt_kind_t;
  typedef logic [7:0] byte_q_t[$];

  // Track one header packet and hold the results it must produce
  class opus_header_tracker;
    out_t        parsed_results[$];
    int          errors;
    int unsigned byte_pos;
    bit          failed;
    logic [7:0]  version_q;
    logic [7:0]  channels_q;
    logic [7:0]  family_q;
    logic [7:0]  streams_q;
    logic [7:0]  coupled_q;
    logic [15:0] preskip_q;
    logic [15:0] gain_q;
    logic [31:0] rate_q;

    function new();
      errors = 0;
      clear_packet();
    endfunction

    function void clear_packet();
      byte_pos   = 0;
      failed     = 1'b0;
      version_q  = '0;
      channels_q = '0;
      family_q   = '0;
      streams_q  = '0;
      coupled_q  = '0;
      preskip_q  = '0;
      gain_q     = '0;
      rate_q     = '0;
    endfunction

    // Parse one accepted byte and queue any result it causes
    function void note_byte(in_t t);
      string       magic = "OpusHead";
      int unsigned pos;
      int unsigned len;
      int unsigned need;
      int unsigned idx;
      bit          is_map;
      logic [7:0]  b;
      out_t        r;
      b = t.data_byte;
      pos = byte_pos;
      idx = 0;
      is_map = 1'b0;
      if (!failed) begin
        if (pos < POS_VERSION) begin
          if (b != magic[pos]) failed = 1'b1;
        end else if (pos == POS_VERSION) begin
          version_q = b;
          if ((b & VERSION_MASK) != 0) failed = 1'b1;
        end else if (pos == POS_CHANNELS) begin
          channels_q = b;
          if (b == 0) failed = 1'b1;
        end else if (pos < POS_RATE) begin
          preskip_q[8*(pos-POS_PRESKIP) +: 8] = b;
        end else if (pos < POS_GAIN) begin
          rate_q[8*(pos-POS_RATE) +: 8] = b;
        end else if (pos < POS_FAMILY) begin
          gain_q[8*(pos-POS_GAIN) +: 8] = b;
        end else if (pos == POS_FAMILY) begin
          family_q = b;
          if (b == 0) begin
            if (channels_q > 2) failed = 1'b1;
            streams_q = 8'd1;
            coupled_q = (channels_q > 1) ? 8'd1 : 8'd0;
          end
        end else if (family_q != 0) begin
          if (pos == POS_STREAMS) begin
            streams_q = b;
            if (b == 0) failed = 1'b1;
          end else if (pos == POS_COUPLED) begin
            coupled_q = b;
            if (b > streams_q || int'(b) + int'(streams_q) > 255) failed = 1'b1;
          end else if (pos - POS_MAP < channels_q) begin
            idx = pos - POS_MAP;
            if (int'(b) >= int'(streams_q) + int'(coupled_q) && b != SILENT) failed = 1'b1;
            else is_map = 1'b1;
          end
        end
      end
      byte_pos = (pos + 1 > COUNT_MAX) ? COUNT_MAX : pos + 1;

      r = '0;
      if (!t.last_byte) begin
        if (is_map && !failed) begin
          r.result_kind = KIND_MAP;
          r.map_index = idx[7:0];
          r.map_value = b;
          parsed_results.push_back(r);
        end
        return;
      end

      // Final byte: decide the verdict and start over
      len = pos + 1;
      need = (family_q == 0) ? MIN_LEN : MAP_BASE + channels_q;
      r.result_kind = KIND_VERDICT;
      r.header_ok = !failed && len >= MIN_LEN && len >= need;
      if (r.header_ok && version_q <= 1 && len != need) r.header_ok = 1'b0;
      if (r.header_ok) begin
        r.version = version_q;
        r.channel_count = channels_q;
        r.preskip = preskip_q;
        r.sample_rate = rate_q;
        r.output_gain = gain_q;
        r.mapping_family = family_q;
        r.stream_count = streams_q;
        r.coupled_count = coupled_q;
        if (is_map) begin
          r.map_index = idx[7:0];
          r.map_value = b;
        end
      end
      parsed_results.push_back(r);
      clear_packet();
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        errors++;
      end
    endfunction

    // Match a result against the oldest one still owed
    function void check_result(out_t r);
      out_t e;
      if (parsed_results.size() == 0) begin
        $error("result with nothing pending: %p", r);
        errors++;
        return;
      end
      e = parsed_results.pop_front();
      compare_field("result_kind", e.result_kind, r.result_kind);
      compare_field("header_ok", e.header_ok, r.header_ok);
      compare_field("version", e.version, r.version);
      compare_field("channel_count", e.channel_count, r.channel_count);
      compare_field("preskip", e.preskip, r.preskip);
      compare_field("sample_rate", e.sample_rate, r.sample_rate);
      compare_field("output_gain", e.output_gain, r.output_gain);
      compare_field("mapping_family", e.mapping_family, r.mapping_family);
      compare_field("stream_count", e.stream_count, r.stream_count);
      compare_field("coupled_count", e.coupled_count, r.coupled_count);
      compare_field("map_index", e.map_index, r.map_index);
      compare_field("map_value", e.map_value, r.map_value);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  opus_header_tracker tracker = new();
  int cycles = 0;
  int bytes_sent = 0;
  int stall_left = 0;

  opus_id_header_parser dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk       = 1'b0;
    rst       = 1'b1;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pick an idle length: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Alternate free runs and stall runs on the result side
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (out_stall) begin
      out_stall <= 1'b0;
      stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
    end else begin
      stall_left = pick_gap();
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end
    end
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) tracker.check_result(out_data);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Present one byte and hold it until the block takes it
  task automatic send_byte(input logic [7:0] b, input logic last, input bit calm);
    int gap;
    @(negedge clk);
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, last_byte: last};
    do @(posedge clk); while (in_stall);
    tracker.note_byte(in_data);
    bytes_sent++;
  endtask

  task automatic send_packet(input byte_q_t pkt, input bit calm);
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1, calm);
  endtask

  // Drop valid and hold off until every owed result has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (tracker.parsed_results.size() != 0) @(negedge clk);
  endtask

  // Build a header packet, mostly well formed, sometimes damaged
  function automatic void build_packet(input pkt_kind_t kind, ref byte_q_t pkt);
    string magic = "OpusHead";
    int ver;
    int ch;
    int st;
    int cp;
    int hi;
    int r;
    int n;
    pkt.delete();
    if (kind == PKT_NOISE) begin
      n = $urandom_range(1, 30);
      repeat (n) pkt.push_back(8'($urandom));
      if ($urandom_range(0, 1)) begin
        for (int i = 0; i < 8 && i < n; i++) pkt[i] = magic[i];
      end
      return;
    end
    for (int i = 0; i < 8; i++) pkt.push_back(magic[i]);
    ver = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15);
    if (kind == PKT_FAMILY_ZERO)
      ch = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 2);
    else
      ch = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 8);
    pkt.push_back(8'(ver));
    pkt.push_back(8'(ch));
    repeat (8) pkt.push_back(8'($urandom));
    if (kind == PKT_FAMILY_ZERO) begin
      pkt.push_back(8'd0);
    end else begin
      pkt.push_back(8'($urandom_range(1, 255)));
      if ($urandom_range(0, 19) == 0) st = 0;
      else if ($urandom_range(0, 7) == 0) st = $urandom_range(1, 255);
      else st = $urandom_range(1, 4);
      hi = (st < 255 - st) ? st : 255 - st;
      cp = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 255) : $urandom_range(0, hi);
      pkt.push_back(8'(st));
      pkt.push_back(8'(cp));
      for (int i = 0; i < ch; i++) begin
        r = $urandom_range(0, 9);
        if (r == 0) pkt.push_back(SILENT);
        else if (r == 1) pkt.push_back(8'($urandom));
        else pkt.push_back(8'($urandom_range(0, (st + cp > 0) ? st + cp - 1 : 0)));
      end
    end
    // later versions may carry extra data
    if (ver > 1 && $urandom_range(0, 2) == 0) repeat ($urandom_range(1, 6)) pkt.push_back(8'($urandom));
    r = $urandom_range(0, 9);
    if (r == 0) pkt[$urandom_range(0, pkt.size() - 1)] = 8'($urandom);
    else if (r == 1) pkt = pkt[0:$urandom_range(0, pkt.size() - 1)];
    else if (r == 2) repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom));
  endfunction

  // Pad a packet past the byte counter's ceiling
  function automatic void n_fill(ref byte_q_t pkt);
    int n;
    n = $urandom_range(COUNT_MAX + 1, COUNT_MAX + 9);
    while (pkt.size() < n) pkt.push_back(8'($urandom));
  endfunction

  initial begin
    byte_q_t pkt;
    pkt_kind_t kind;
    int start;
    int pkt_no;
    int r;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Valid family 1 header with extreme fields; its last byte is a silent map entry
    pkt = {8'h4F, 8'h70, 8'h75, 8'h73, 8'h48, 8'h65, 8'h61, 8'h64,
           8'h0F, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
           8'h00, 8'h80, 8'h01, 8'h01, 8'h00, 8'hFF};
    send_packet(pkt, 1'b0);
    // One-byte packet: too short
    pkt = {8'h00};
    send_packet(pkt, 1'b1);
    drain_results();

    // Random packets
    start = bytes_sent;
    pkt_no = 0;
    while (bytes_sent - start < RANDOM_BYTES) begin
      if (pkt_no == LONG_PACKET) begin
        // saturate the byte counter with a long trailing tail
        build_packet(PKT_FAMILY_ZERO, pkt);
        n_fill(pkt);
      end else begin
        r = $urandom_range(0, 9);
        kind = (r < 4) ? PKT_FAMILY_ZERO : (r < 8) ? PKT_MAPPED : PKT_NOISE;
        build_packet(kind, pkt);
      end
      send_packet(pkt, $urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0) drain_results();
      pkt_no++;
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.parsed_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
